@@ hdl/dtoi64_pkg.sv @@
// Package for the decimal text to int64 converter.
// Holds the beat structs, status and phase codes, and the character constants.
// No dependencies.
package dtoi64_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int BASE_BITS   = 6;

    localparam logic [BASE_BITS-1:0]   DECIMAL_BASE = BASE_BITS'(10);
    localparam logic [OFFSET_BITS-1:0] POS_MAX      = {OFFSET_BITS{1'b1}};
    localparam logic [63:0]            MAG_POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0]            MAG_NEG_LIMIT = 64'h8000_0000_0000_0000;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_DIGITS = 2'd1,
        ST_RANGE     = 2'd2,
        ST_BAD_BASE  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_BLANK  = 4'b0010,
        PH_SIGNED = 4'b0100,
        PH_DIGITS = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       string_start;
    } in_beat_t;

    typedef struct packed {
        logic signed [63:0] parsed_value;
        logic [15:0]        stop_offset;
        logic [1:0]         status_code;
    } out_beat_t;

endpackage

@@ hdl/decimal_text_to_int64_top.sv @@
// Top level of the decimal text to int64 converter.
// Depends on dtoi64_pkg.
//
// Usage:
//   s_valid/s_ready/s_beat carry one character per beat; string_start marks
//   the first character of a string. Blanks and one sign are skipped, then
//   decimal digits accumulate. One result per string leaves on
//   m_valid/m_ready/m_beat when the parse ends (non-digit, NUL, overflow,
//   no digits, or bad base at the string start).
//   cfg_valid/cfg_ready/cfg_data writes number_base; write only while idle.
// Path: the beat ending the parse is registered in the input register, then the
//   digit multiply-add/limit compare feeds the result register that drives
//   m_valid/m_beat.
// Throughput: one character per cycle while no result waits with m_ready low;
//   the accumulate-by-ten loop feeds back on the accumulator.
// Reset: number_base returns to 10, the parser goes idle (awaiting a string
//   start), both pipeline registers empty.
// Stall: while a result waits with m_ready low, the stage that could produce
//   the next result holds, and s_ready drops once the input register is full.
module decimal_text_to_int64_top
    import dtoi64_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_beat_t             s_beat,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_beat_t            m_beat,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [BASE_BITS-1:0] cfg_data
);

    logic [BASE_BITS-1:0]   base_reg;
    logic                   in_valid_reg;
    in_beat_t               in_reg;
    phase_t                 phase_reg, phase_next;
    logic [63:0]            acc_reg, acc_next;
    logic                   neg_reg, neg_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic                   out_valid_reg;
    out_beat_t              out_reg, out_next;

    logic                   advance;
    logic                   emit;
    phase_t                 phase_w;
    logic [63:0]            acc_w;
    logic                   neg_w;
    logic [OFFSET_BITS-1:0] pos_w;
    logic [7:0]             c;
    logic                   is_blank, is_digit;
    logic [3:0]             digit;
    logic [67:0]            prod;
    logic [63:0]            lim;
    logic                   ovf;
    logic                   count_pos;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_beat    = out_reg;

    assign c        = in_reg.char_code;
    assign is_blank = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    assign digit    = 4'(c - CHAR_ZERO);

    assign acc_w = in_reg.string_start ? 64'd0 : acc_reg;
    assign neg_w = in_reg.string_start ? 1'b0 : neg_reg;
    assign pos_w = in_reg.string_start ? '0 : pos_reg;

    // 10*acc + d, overflow when it passes the magnitude limit for the sign
    assign prod = {1'b0, acc_w, 3'b000} + {3'b000, acc_w, 1'b0} + {64'd0, digit};
    assign lim  = MAG_POS_LIMIT + {63'd0, neg_w};
    assign ovf  = prod > {4'd0, lim};

    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        pos_next   = pos_reg;
        emit       = 1'b0;
        count_pos  = 1'b0;
        out_next   = out_reg;
        phase_w    = in_reg.string_start ? PH_BLANK : phase_reg;
        if (in_valid_reg && advance) begin
            acc_next = acc_w;
            neg_next = neg_w;
            pos_next = pos_w;
            if (in_reg.string_start && base_reg != DECIMAL_BASE) begin
                emit       = 1'b1;
                phase_next = PH_IDLE;
                out_next   = '{parsed_value: 64'sd0, stop_offset: 16'd0,
                               status_code: ST_BAD_BASE};
            end else begin
                count_pos  = (phase_w != PH_IDLE);
                phase_next = phase_w;
                unique case (phase_w)
                    PH_IDLE: begin
                    end
                    PH_BLANK, PH_SIGNED, PH_DIGITS: begin
                        if (is_digit) begin
                            if (ovf) begin
                                emit       = 1'b1;
                                phase_next = PH_IDLE;
                                out_next   = '{
                                    parsed_value: neg_w ? MAG_NEG_LIMIT : MAG_POS_LIMIT,
                                    stop_offset:  16'(pos_w),
                                    status_code:  ST_RANGE};
                            end else begin
                                acc_next   = prod[63:0];
                                phase_next = PH_DIGITS;
                            end
                        end else if (phase_w == PH_BLANK && is_blank) begin
                            phase_next = PH_BLANK;
                        end else if (phase_w == PH_BLANK &&
                                     (c == CHAR_PLUS || c == CHAR_MINUS)) begin
                            neg_next   = (c == CHAR_MINUS);
                            phase_next = PH_SIGNED;
                        end else if (phase_w == PH_DIGITS) begin
                            emit       = 1'b1;
                            phase_next = PH_IDLE;
                            out_next   = '{
                                parsed_value: neg_w ? (64'd0 - acc_w) : acc_w,
                                stop_offset:  16'(pos_w),
                                status_code:  ST_OK};
                        end else begin
                            emit       = 1'b1;
                            phase_next = PH_IDLE;
                            out_next   = '{parsed_value: 64'sd0, stop_offset: 16'd0,
                                           status_code: ST_NO_DIGITS};
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
                if (count_pos && pos_w < POS_MAX) begin
                    pos_next = pos_w + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg      <= DECIMAL_BASE;
            in_valid_reg  <= 1'b0;
            phase_reg     <= PH_IDLE;
            acc_reg       <= 64'd0;
            neg_reg       <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                base_reg <= cfg_data;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            pos_reg   <= pos_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_beat;
        end
        if (emit) begin
            out_reg <= out_next;
        end
    end

endmodule

@@ hdl/dtoi64_checker.sv @@
// Port-level checker for decimal_text_to_int64_top, with its bind.
// Depends on dtoi64_pkg.
module dtoi64_checker
    import dtoi64_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_valid,
    input logic                 m_ready,
    input out_beat_t            m_beat
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_beat))
        else $error("result beat changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_bad_base: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_beat.status_code == ST_BAD_BASE |->
            m_beat.parsed_value == 64'sd0 && m_beat.stop_offset == 16'd0)
        else $error("bad-base result not zero");

    a_no_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_beat.status_code == ST_NO_DIGITS |->
            m_beat.parsed_value == 64'sd0 && m_beat.stop_offset == 16'd0)
        else $error("no-digit result not zero");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_beat.status_code == ST_RANGE |->
            m_beat.parsed_value == MAG_POS_LIMIT ||
            m_beat.parsed_value == MAG_NEG_LIMIT)
        else $error("range result not a limit");

endmodule

bind decimal_text_to_int64_top dtoi64_checker u_dtoi64_checker (.*);

@@ dv/tb_decimal_text_to_int64_top.sv @@
// Self-checking testbench for decimal_text_to_int64_top.
// Drives a directed table of characters, then random strings at several radix settings, and
// checks each result against typed rows or a cycle-free parser model. Depends on dtoi64_pkg.
module tb_decimal_text_to_int64_top;
    import dtoi64_pkg::*;

    typedef struct {
        logic [7:0]         ch;
        logic               start;
        bit                 typed;
        logic signed [63:0] val;
        logic [15:0]        off;
        status_t            sc;
    } dir_row_t;

    localparam int DIR_ROWS = 25;
    localparam int PHASES   = 9;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    in_beat_t             s_beat;
    logic                 m_valid;
    logic                 m_ready;
    out_beat_t            m_beat;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [BASE_BITS-1:0] cfg_data;

    // parser model state
    logic [BASE_BITS-1:0]   radix_reg;
    phase_t                 parse_phase;
    logic [63:0]            magnitude;
    logic                   negative;
    logic [OFFSET_BITS-1:0] char_pos;

    out_beat_t   expected_parses[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned live_chars;
    bit          quiet;

    // directed table: typed rows carry the result read straight off the string
    dir_row_t dir_table [DIR_ROWS] = '{
        '{"5",        1'b1, 1'b0, 0,  0, ST_OK},
        '{CHAR_NUL,   1'b0, 1'b1, 5,  1, ST_OK},
        '{CHAR_TAB,   1'b1, 1'b0, 0,  0, ST_OK},
        '{CHAR_SPACE, 1'b0, 1'b0, 0,  0, ST_OK},
        '{CHAR_MINUS, 1'b0, 1'b0, 0,  0, ST_OK},
        '{"7",        1'b0, 1'b0, 0,  0, ST_OK},
        '{8'hFF,      1'b0, 1'b1, -7, 4, ST_OK},
        '{CHAR_PLUS,  1'b1, 1'b0, 0,  0, ST_OK},
        '{"x",        1'b0, 1'b1, 0,  0, ST_NO_DIGITS},
        '{"a",        1'b1, 1'b1, 0,  0, ST_NO_DIGITS},
        '{"3",        1'b0, 1'b0, 0,  0, ST_OK},
        '{"1",        1'b1, 1'b0, 0,  0, ST_OK},
        '{"2",        1'b0, 1'b0, 0,  0, ST_OK},
        '{"4",        1'b1, 1'b0, 0,  0, ST_OK},
        '{"0",        1'b0, 1'b0, 0,  0, ST_OK},
        '{CHAR_CR,    1'b0, 1'b1, 40, 2, ST_OK},
        '{CHAR_MINUS, 1'b1, 1'b0, 0,  0, ST_OK},
        '{CHAR_MINUS, 1'b0, 1'b1, 0,  0, ST_NO_DIGITS},
        '{CHAR_NUL,   1'b1, 1'b1, 0,  0, ST_NO_DIGITS},
        '{"0",        1'b1, 1'b0, 0,  0, ST_OK},
        '{"9",        1'b0, 1'b0, 0,  0, ST_OK},
        '{"/",        1'b0, 1'b0, 0,  0, ST_OK},
        '{"1",        1'b1, 1'b0, 0,  0, ST_OK},
        '{":",        1'b0, 1'b0, 0,  0, ST_OK},
        '{"8",        1'b0, 1'b0, 0,  0, ST_OK}
    };

    logic [BASE_BITS-1:0] phase_radix [PHASES] = '{
        BASE_BITS'(0), DECIMAL_BASE, BASE_BITS'(63), DECIMAL_BASE, BASE_BITS'(36),
        DECIMAL_BASE, BASE_BITS'(11), BASE_BITS'(9), DECIMAL_BASE
    };
    int unsigned phase_items [PHASES] = '{20, 150, 20, 150, 20, 120, 20, 20, 130};

    decimal_text_to_int64_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_beat    (s_beat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_beat    (m_beat),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic int unsigned idle_span();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] blank_char();
        logic [7:0] r;
        r = 8'($urandom_range(0, 5));
        return (r == 8'd5) ? CHAR_SPACE : CHAR_TAB + r;
    endfunction

    function automatic logic [7:0] digit_char();
        return CHAR_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // Accumulates one digit; on overflow fills r with the saturated result.
    function automatic bit accumulate_digit(input logic [7:0] c, output out_beat_t r);
        logic [63:0] d;
        logic [63:0] lim;
        d   = {56'd0, c - CHAR_ZERO};
        lim = MAG_POS_LIMIT + {63'd0, negative};
        r   = '0;
        if (magnitude > (lim - d) / 10) begin
            r.parsed_value = negative ? MAG_NEG_LIMIT : MAG_POS_LIMIT;
            r.stop_offset  = char_pos;
            r.status_code  = ST_RANGE;
            parse_phase    = PH_IDLE;
            return 1'b1;
        end
        magnitude   = magnitude * 10 + d;
        parse_phase = PH_DIGITS;
        return 1'b0;
    endfunction

    // Advances the parser model by one character; returns 1 when the parse ends.
    function automatic bit parse_char(input in_beat_t b, output out_beat_t r);
        logic [7:0] c;
        bit         is_dig;
        bit         is_blank;
        bit         done;
        c        = b.char_code;
        is_dig   = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        is_blank = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
        done     = 1'b0;
        r        = '0;
        if (b.string_start) begin
            char_pos  = '0;
            magnitude = '0;
            negative  = 1'b0;
            if (radix_reg != DECIMAL_BASE) begin
                r.status_code = ST_BAD_BASE;
                parse_phase   = PH_IDLE;
                return 1'b1;
            end
            parse_phase = PH_BLANK;
        end
        if (parse_phase == PH_IDLE) return 1'b0;

        case (parse_phase)
            PH_BLANK: begin
                if (is_blank) begin
                end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                    negative    = (c == CHAR_MINUS);
                    parse_phase = PH_SIGNED;
                end else if (is_dig) begin
                    done = accumulate_digit(c, r);
                end else begin
                    r.status_code = ST_NO_DIGITS;
                    parse_phase   = PH_IDLE;
                    done          = 1'b1;
                end
            end
            PH_SIGNED: begin
                if (is_dig) begin
                    done = accumulate_digit(c, r);
                end else begin
                    r.status_code = ST_NO_DIGITS;
                    parse_phase   = PH_IDLE;
                    done          = 1'b1;
                end
            end
            default: begin
                if (is_dig) begin
                    done = accumulate_digit(c, r);
                end else begin
                    r.parsed_value = negative ? -magnitude : magnitude;
                    r.stop_offset  = char_pos;
                    r.status_code  = ST_OK;
                    parse_phase    = PH_IDLE;
                    done           = 1'b1;
                end
            end
        endcase

        if (char_pos != POS_MAX) char_pos = char_pos + 1'b1;
        return done;
    endfunction

    task automatic push_char(input in_beat_t b, input bit typed, input out_beat_t typed_r);
        out_beat_t   r;
        bit          hit;
        int unsigned gap;
        s_valid <= 1'b1;
        s_beat  <= b;
        do @(posedge aclk); while (!s_ready);
        live_chars++;
        hit = parse_char(b, r);
        if (typed) expected_parses.push_back(typed_r);
        else if (hit) expected_parses.push_back(r);
        gap = quiet ? 0 : idle_span();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stop sending and let every pending result drain out of the pipeline.
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_parses.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_radix(input logic [BASE_BITS-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        radix_reg = v;
    endtask

    task automatic send_random_string();
        in_beat_t   seq[$];
        out_beat_t  none;
        logic [7:0] t;
        string      near_limit;
        int unsigned mode;
        none       = '0;
        near_limit = "922337203685477580";
        if ($urandom_range(0, 3) != 0) begin
            seq.push_back('{char_code: blank_char(), string_start: 1'b1});
            if ($urandom_range(0, 1) == 0) void'(seq.pop_back());
            repeat ($urandom_range(0, 3))
                seq.push_back('{char_code: blank_char(), string_start: 1'b0});
            case ($urandom_range(0, 2))
                1: seq.push_back('{char_code: CHAR_PLUS, string_start: 1'b0});
                2: seq.push_back('{char_code: CHAR_MINUS, string_start: 1'b0});
                default: ;
            endcase
            mode = $urandom_range(0, 9);
            if (mode == 8) begin
                // the signed limit's digits but its last, then one or two random digits
                for (int i = 0; i < near_limit.len(); i++)
                    seq.push_back('{char_code: near_limit[i], string_start: 1'b0});
                repeat ($urandom_range(1, 2))
                    seq.push_back('{char_code: digit_char(), string_start: 1'b0});
            end else begin
                if (mode == 9)
                    repeat ($urandom_range(1, 4))
                        seq.push_back('{char_code: CHAR_ZERO, string_start: 1'b0});
                repeat ((mode == 6 || mode == 7) ? $urandom_range(15, 21) : $urandom_range(1, 5))
                    seq.push_back('{char_code: digit_char(), string_start: 1'b0});
            end
            if ($urandom_range(0, 9) != 0) begin
                if ($urandom_range(0, 4) < 2) begin
                    t = CHAR_NUL;
                end else begin
                    do t = 8'($urandom); while (t >= CHAR_ZERO && t <= CHAR_NINE);
                end
                seq.push_back('{char_code: t, string_start: 1'b0});
            end
            repeat ($urandom_range(0, 2))
                seq.push_back('{char_code: 8'($urandom), string_start: 1'b0});
            seq[0].string_start = 1'b1;
        end else begin
            // noise: random bytes, stray string starts
            repeat ($urandom_range(1, 6))
                seq.push_back('{char_code: 8'($urandom),
                                string_start: ($urandom_range(0, 3) == 0)});
            seq[0].string_start = ($urandom_range(0, 9) != 0);
        end
        foreach (seq[i]) push_char(seq[i], 1'b0, none);
    endtask

    always @(posedge aclk) begin : check_results
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_parses.size() == 0) begin
                $write("%0t unexpected result: expected none, ", $time);
                $display("got value %0d offset %0d status %0d",
                         m_beat.parsed_value, m_beat.stop_offset, m_beat.status_code);
                mismatches++;
            end else begin
                want = expected_parses.pop_front();
                if (m_beat.parsed_value !== want.parsed_value ||
                    m_beat.stop_offset  !== want.stop_offset  ||
                    m_beat.status_code  !== want.status_code) begin
                    $write("%0t mismatch: expected value %0d offset %0d status %0d, ",
                           $time, want.parsed_value, want.stop_offset, want.status_code);
                    $display("got value %0d offset %0d status %0d",
                             m_beat.parsed_value, m_beat.stop_offset, m_beat.status_code);
                    mismatches++;
                end
            end
        end
    end

    // result side back-pressure; one long hold-off once traffic is flowing
    initial begin : result_sink
        bit          held;
        int unsigned n;
        held = 1'b0;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (!held && results_seen >= 20) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(0, 7) == 0 ? 80 : $urandom_range(1, 20)) @(posedge aclk);
            n = idle_span();
            if (n != 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        in_beat_t    b;
        out_beat_t   r;
        int unsigned first;
        int unsigned w;
        bit          paused;

        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_beat    <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        radix_reg   = DECIMAL_BASE;
        parse_phase = PH_IDLE;
        magnitude   = '0;
        negative    = 1'b0;
        char_pos    = '0;
        mismatches   = 0;
        results_seen = 0;
        live_chars   = 0;
        quiet        = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_table[i]) begin
            b.char_code    = dir_table[i].ch;
            b.string_start = dir_table[i].start;
            r.parsed_value = dir_table[i].val;
            r.stop_offset  = dir_table[i].off;
            r.status_code  = dir_table[i].sc;
            push_char(b, dir_table[i].typed, r);
        end

        for (int p = 0; p < PHASES; p++) begin
            settle();
            write_radix(phase_radix[p]);
            quiet  = (p == 5);
            paused = 1'b0;
            first  = live_chars;
            while (live_chars - first < phase_items[p]) begin
                send_random_string();
                if (p == 3 && !paused && live_chars - first >= phase_items[p] / 2) begin
                    settle();
                    paused = 1'b1;
                end
            end
        end
        s_valid <= 1'b0;

        for (w = 0; expected_parses.size() != 0 && w < 20000; w++) @(posedge aclk);
        if (expected_parses.size() != 0) begin
            $display("%0t %0d expected results never arrived", $time, expected_parses.size());
            mismatches += expected_parses.size();
        end
        repeat (10) @(posedge aclk);
        if (mismatches == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/dtoi64_pkg.sv
hdl/decimal_text_to_int64_top.sv
hdl/dtoi64_checker.sv
dv/tb_decimal_text_to_int64_top.sv
